// ----- rtl/rtcm3_frame_sync_crc24q_core_defines.svh -----
// ----------------------------------------------------------------------------
// rtcm3 frame sync assertion macros
// assertion helpers shared by the rtl, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef RTCM3_FRAME_SYNC_CRC24Q_CORE_DEFINES_SVH
`define RTCM3_FRAME_SYNC_CRC24Q_CORE_DEFINES_SVH

`ifndef SYNTH
`define RFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RFS_ASSERT(lbl, clk, rst_n, prop)
`define RFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/rtcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcm frame sync package
// constants, report record and control structs, crc-24q byte update
// ----------------------------------------------------------------------------
package rtcm_pkg;

    localparam int BUFFER_BYTES_DEF = 2048;
    localparam int MAX_REPORTS      = 64;
    localparam int REP_IW           = 6;
    localparam int REP_CW           = 7;
    localparam int HDR_LEN          = 3;
    localparam int CRC_LEN          = 3;
    localparam int MIN_LEN          = 6;

    localparam logic [7:0]  SYNC_BYTE = 8'hD3;
    localparam logic [7:0]  RSV_MASK  = 8'hFC;
    localparam logic [24:0] CRC_POLY  = 25'h1864CFB;
    localparam logic [24:0] CRC_TOP   = 25'h1000000;

    typedef struct packed {
        logic [9:0]  len;
        logic [23:0] calc;
        logic [23:0] rx;
        logic        ok;
        logic [11:0] mtype;
    } rep_t;

    typedef struct packed {
        logic clear;
        logic step;
    } crc_ctl_t;

    typedef struct packed {
        logic push;
        logic rd_en;
        logic rd_adv;
        logic clear;
    } rep_ctl_t;

    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int i = 0; i < 8; i++) begin
            c = {c[23:0], 1'b0};
            if ((c & CRC_TOP) != '0) begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

// ----- rtl/rtcm_crc_unit.sv -----
// ----------------------------------------------------------------------------
// rtcm crc unit
// crc-24q accumulator, one byte per step
// ----------------------------------------------------------------------------
module rtcm_crc_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtcm_pkg::crc_ctl_t ctl,
    input  logic [7:0]        din,
    output logic [23:0]       crc
);
    import rtcm_pkg::*;

    logic [23:0] crc_reg;
    logic [23:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctl.clear) begin
            crc_next = '0;
        end else if (ctl.step) begin
            crc_next = crc24q_byte(crc_reg, din);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// ----- rtl/rtcm_rep_buf.sv -----
// ----------------------------------------------------------------------------
// rtcm report buffer
// holds the reports of one request until the step ends, then replays them
// ----------------------------------------------------------------------------
module rtcm_rep_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rtcm_pkg::rep_ctl_t          ctl,
    input  rtcm_pkg::rep_t              wr_rep,
    output rtcm_pkg::rep_t              rd_rep,
    output logic [rtcm_pkg::REP_CW-1:0] cnt,
    output logic                        full,
    output logic                        rd_last
);
    import rtcm_pkg::*;

    rep_t              mem [MAX_REPORTS];
    rep_t              rd_rep_reg;
    logic [REP_CW-1:0] cnt_reg;
    logic [REP_CW-1:0] cnt_next;
    logic [REP_IW-1:0] rd_idx_reg;
    logic [REP_IW-1:0] rd_idx_next;

    always_comb begin
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        if (ctl.clear) begin
            cnt_next    = '0;
            rd_idx_next = '0;
        end else begin
            if (ctl.push) begin
                cnt_next = cnt_reg + REP_CW'(1);
            end
            if (ctl.rd_adv) begin
                rd_idx_next = rd_idx_reg + REP_IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[cnt_reg[REP_IW-1:0]] <= wr_rep;
        end
        if (ctl.rd_en) begin
            rd_rep_reg <= mem[rd_idx_reg];
        end
    end

    assign rd_rep  = rd_rep_reg;
    assign cnt     = cnt_reg;
    assign full    = (cnt_reg == REP_CW'(MAX_REPORTS));
    assign rd_last = ({1'b0, rd_idx_reg} + REP_CW'(1)) == cnt_reg;

endmodule

// ----- rtl/rtcm3_frame_sync_crc24q_core.sv -----
// ----------------------------------------------------------------------------
// rtcm3 frame sync and crc-24q check
// one request stores its byte, then the scanner drops each byte that does not
// open a valid header, stops at a header still waiting on its frame bytes, and
// checks each complete candidate frame through the shared crc unit and the
// single byte store read port; each report then waits on m_ready.
// synchronous active-low reset clears pointers, counts and state;
// the byte store is not cleared and needs no sweep
// ----------------------------------------------------------------------------
`include "rtcm3_frame_sync_crc24q_core_defines.svh"

module rtcm3_frame_sync_crc24q_core #(
    parameter int BUFFER_BYTES = rtcm_pkg::BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_pay_len,
    output logic [23:0] m_calc_crc,
    output logic [23:0] m_received_crc,
    output logic        m_crc_ok,
    output logic [11:0] m_message_type,
    output logic        m_last_report,
    output logic        m_reports_dropped
);
    import rtcm_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam logic [AW:0] BUF_EXT = (AW+1)'(BUFFER_BYTES);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SCAN  = 13'b0000000000010,
        ST_H0    = 13'b0000000000100,
        ST_H1    = 13'b0000000001000,
        ST_H2    = 13'b0000000010000,
        ST_CRC   = 13'b0000000100000,
        ST_RX0   = 13'b0000001000000,
        ST_RX1   = 13'b0000010000000,
        ST_RX2   = 13'b0000100000000,
        ST_REP   = 13'b0001000000000,
        ST_FIN   = 13'b0010000000000,
        ST_DRAIN = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= BUF_EXT) begin
            s = s - BUF_EXT;
        end
        return s[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     off_reg, off_next;
    logic [1:0]        lenhi_reg, lenhi_next;
    logic [9:0]        len_reg, len_next;
    logic [7:0]        b3_reg, b3_next;
    logic [7:0]        b4_reg, b4_next;
    logic [23:0]       rx_reg, rx_next;
    logic              dropped_reg, dropped_next;

    logic [7:0]        store [BUFFER_BYTES];
    logic [7:0]        rdata_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    crc_ctl_t          crc_ctl;
    logic [23:0]       crc_val;
    rep_ctl_t          rep_ctl;
    rep_t              rep_in;
    rep_t              rep_out;
    logic [REP_CW-1:0] rep_cnt;
    logic              rep_full;
    logic              rep_last;

    logic [AW-1:0]     head1;
    logic [FW-1:0]     fill1;
    logic [AW-1:0]     total;
    logic [AW-1:0]     drop_n;
    logic              ok;

    rtcm_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .din     (rdata_reg),
        .crc     (crc_val)
    );

    rtcm_rep_buf u_rep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rep_ctl),
        .wr_rep  (rep_in),
        .rd_rep  (rep_out),
        .cnt     (rep_cnt),
        .full    (rep_full),
        .rd_last (rep_last)
    );

    assign total = AW'(len_reg) + AW'(HDR_LEN + CRC_LEN);
    assign ok    = (crc_val == rx_reg);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        off_next     = off_reg;
        lenhi_next   = lenhi_reg;
        len_next     = len_reg;
        b3_next      = b3_reg;
        b4_next      = b4_reg;
        rx_next      = rx_reg;
        dropped_next = dropped_reg;
        wr_en        = 1'b0;
        head1        = head_reg;
        fill1        = fill_reg;
        wr_addr      = head_reg;
        drop_n       = AW'(1);
        crc_ctl      = '0;
        rep_ctl      = '0;
        rep_in.len   = len_reg;
        rep_in.calc  = crc_val;
        rep_in.rx    = rx_reg;
        rep_in.ok    = ok;
        rep_in.mtype = (ok && len_reg >= 10'd2) ? {b3_reg, b4_reg[7:4]} : 12'h000;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (fill_reg == FW'(BUFFER_BYTES)) begin
                        head1 = wrap(head_reg, AW'(1));
                        fill1 = fill_reg - FW'(1);
                    end
                    wr_en      = 1'b1;
                    wr_addr    = wrap(head1, fill1[AW-1:0]);
                    head_next  = head1;
                    fill_next  = fill1 + FW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (fill_reg < FW'(MIN_LEN)) begin
                    state_next = ST_FIN;
                end else begin
                    off_next   = '0;
                    state_next = ST_H0;
                end
            end
            ST_H0: begin
                if (rdata_reg != SYNC_BYTE) begin
                    head_next  = wrap(head_reg, AW'(1));
                    fill_next  = fill_reg - FW'(1);
                    state_next = ST_SCAN;
                end else begin
                    off_next   = AW'(1);
                    state_next = ST_H1;
                end
            end
            ST_H1: begin
                if ((rdata_reg & RSV_MASK) != 8'h00) begin
                    head_next  = wrap(head_reg, AW'(1));
                    fill_next  = fill_reg - FW'(1);
                    state_next = ST_SCAN;
                end else begin
                    lenhi_next = rdata_reg[1:0];
                    off_next   = AW'(2);
                    state_next = ST_H2;
                end
            end
            ST_H2: begin
                len_next = {lenhi_reg, rdata_reg};
                if (fill_reg < FW'(AW'({lenhi_reg, rdata_reg}) + AW'(HDR_LEN + CRC_LEN))) begin
                    state_next = ST_FIN;
                end else begin
                    off_next      = '0;
                    crc_ctl.clear = 1'b1;
                    state_next    = ST_CRC;
                end
            end
            ST_CRC: begin
                crc_ctl.step = 1'b1;
                if (off_reg == AW'(HDR_LEN)) begin
                    b3_next = rdata_reg;
                end
                if (off_reg == AW'(HDR_LEN + 1)) begin
                    b4_next = rdata_reg;
                end
                off_next = off_reg + AW'(1);
                if (off_reg == AW'(len_reg) + AW'(HDR_LEN - 1)) begin
                    state_next = ST_RX0;
                end
            end
            ST_RX0: begin
                rx_next[23:16] = rdata_reg;
                off_next       = off_reg + AW'(1);
                state_next     = ST_RX1;
            end
            ST_RX1: begin
                rx_next[15:8] = rdata_reg;
                off_next      = off_reg + AW'(1);
                state_next    = ST_RX2;
            end
            ST_RX2: begin
                rx_next[7:0] = rdata_reg;
                state_next   = ST_REP;
            end
            ST_REP: begin
                if (rep_full) begin
                    dropped_next = 1'b1;
                end else begin
                    rep_ctl.push = 1'b1;
                end
                drop_n     = ok ? total : AW'(1);
                head_next  = wrap(head_reg, drop_n);
                fill_next  = fill_reg - FW'(drop_n);
                state_next = ST_SCAN;
            end
            ST_FIN: begin
                if (rep_cnt == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                rep_ctl.rd_en = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (rep_last) begin
                        rep_ctl.clear = 1'b1;
                        dropped_next  = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        rep_ctl.rd_adv = 1'b1;
                        state_next     = ST_DRAIN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = wrap(head_next, off_next);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= s_data_byte;
        end
        rdata_reg <= store[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            off_reg     <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            off_reg     <= off_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        lenhi_reg <= lenhi_next;
        len_reg   <= len_next;
        b3_reg    <= b3_next;
        b4_reg    <= b4_next;
        rx_reg    <= rx_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = (state_reg == ST_OUT);
    assign m_pay_len         = rep_out.len;
    assign m_calc_crc        = rep_out.calc;
    assign m_received_crc    = rep_out.rx;
    assign m_crc_ok          = rep_out.ok;
    assign m_message_type    = rep_out.mtype;
    assign m_last_report     = rep_last;
    assign m_reports_dropped = dropped_reg;

    `RFS_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FW'(BUFFER_BYTES))
    `RFS_ASSERT(a_idle_empty, aclk, aresetn, s_ready |-> (!m_valid && rep_cnt == '0))
    `RFS_ASSERT(a_drop_full, aclk, aresetn, dropped_reg |-> rep_full)
    `RFS_ASSERT_NEXT(a_rep_rescan, aclk, aresetn, state_reg == ST_REP, state_reg == ST_SCAN)

endmodule

// ----- sim/rtcm3_frame_sync_checker.sv -----
// ----------------------------------------------------------------------------
// rtcm3 frame sync checker
// watches both channels, keeps its own byte store and scanner, works out the
// frame reports each accepted request should cause and compares every report
// field by field against the oldest outstanding one
// ----------------------------------------------------------------------------
module rtcm3_frame_sync_checker #(
    parameter int STORE_DEPTH = rtcm_pkg::BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [9:0]  m_pay_len,
    input  logic [23:0] m_calc_crc,
    input  logic [23:0] m_received_crc,
    input  logic        m_crc_ok,
    input  logic [11:0] m_message_type,
    input  logic        m_last_report,
    input  logic        m_reports_dropped,
    output int          fail_count,
    output int          reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rtcm_pkg::*;

    typedef struct {
        logic [9:0]  len;
        logic [23:0] calc;
        logic [23:0] rx;
        logic        ok;
        logic [11:0] mtype;
        logic        last;
        logic        dropped;
    } frame_report_t;

    logic [7:0]    store [0:STORE_DEPTH-1];
    int unsigned   head;
    int unsigned   fill;
    frame_report_t expected_reports [$];

    function automatic logic [7:0] peek(input int unsigned off);
        return store[(head + off) % STORE_DEPTH];
    endfunction

    task automatic drop_front(input int unsigned n);
        if (n > fill) begin
            n = fill;
        end
        head = (head + n) % STORE_DEPTH;
        fill = fill - n;
    endtask

    function automatic logic [23:0] stored_crc(input int unsigned n);
        logic [24:0] c;
        c = '0;
        for (int unsigned i = 0; i < n; i++) begin
            c[23:16] = c[23:16] ^ peek(i);
            for (int k = 0; k < 8; k++) begin
                c = {c[23:0], 1'b0};
                if (c[24]) begin
                    c = c ^ CRC_POLY;
                end
            end
        end
        return c[23:0];
    endfunction

    task automatic take_byte(input logic [7:0] b);
        frame_report_t batch [$];
        frame_report_t r;
        bit            over;
        int unsigned   len;
        int unsigned   total;
        logic [7:0]    hdr1;
        logic [7:0]    pl1;
        over = 0;
        if (fill >= STORE_DEPTH) begin
            drop_front(1);
        end
        store[(head + fill) % STORE_DEPTH] = b;
        fill++;
        while (fill >= MIN_LEN) begin
            if (peek(0) != SYNC_BYTE || (peek(1) & RSV_MASK) != 0) begin
                drop_front(1);
                continue;
            end
            hdr1  = peek(1);
            len   = 32'({hdr1[1:0], peek(2)});
            total = HDR_LEN + len + CRC_LEN;
            if (fill < total) begin
                break;
            end
            pl1       = peek(HDR_LEN + 1);
            r.len     = len[9:0];
            r.rx      = {peek(HDR_LEN + len), peek(HDR_LEN + len + 1), peek(HDR_LEN + len + 2)};
            r.calc    = stored_crc(HDR_LEN + len);
            r.ok      = (r.calc == r.rx);
            r.mtype   = (r.ok && len >= 2) ? {peek(HDR_LEN), pl1[7:4]} : 12'h000;
            r.last    = 0;
            r.dropped = 0;
            if (batch.size() < MAX_REPORTS) begin
                batch.insert(batch.size(), r);
            end else begin
                over = 1;
            end
            drop_front(r.ok ? total : 1);
        end
        foreach (batch[i]) begin
            batch[i].dropped = over;
            batch[i].last    = (i == batch.size() - 1);
            expected_reports.insert(expected_reports.size(), batch[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        frame_report_t e;
        if (!aresetn) begin
            head = 0;
            fill = 0;
            expected_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected report len", m_pay_len, 0);
                end else begin
                    e = expected_reports.pop_front();
                    if (m_pay_len !== e.len)
                        report_mismatch("pay_len", m_pay_len, e.len);
                    if (m_calc_crc !== e.calc)
                        report_mismatch("calc_crc", m_calc_crc, e.calc);
                    if (m_received_crc !== e.rx)
                        report_mismatch("received_crc", m_received_crc, e.rx);
                    if (m_crc_ok !== e.ok)
                        report_mismatch("crc_ok", m_crc_ok, e.ok);
                    if (m_message_type !== e.mtype)
                        report_mismatch("message_type", m_message_type, e.mtype);
                    if (m_last_report !== e.last)
                        report_mismatch("last_report", m_last_report, e.last);
                    if (m_reports_dropped !== e.dropped)
                        report_mismatch("reports_dropped", m_reports_dropped, e.dropped);
                end
            end
            if (s_valid && s_ready) begin
                take_byte(s_data_byte);
            end
        end
        reports_pending = expected_reports.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// rtcm3 frame sync testbench top
// drives byte requests (good and corrupted frames, noise, bad headers, split
// frames, a report burst past the cap) with random sender gaps and receiver
// stalls, and gives the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [9:0]  m_pay_len;
    logic [23:0] m_calc_crc;
    logic [23:0] m_received_crc;
    logic        m_crc_ok;
    logic [11:0] m_message_type;
    logic        m_last_report;
    logic        m_reports_dropped;

    int fail_count;
    int reports_pending;
    int cycles;
    int bytes_sent;
    int send_idle_pct;
    int recv_stall_pct;

    rtcm3_frame_sync_crc24q_core dut (.*);

    rtcm3_frame_sync_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data_byte,
        .m_valid, .m_ready, .m_pay_len, .m_calc_crc, .m_received_crc,
        .m_crc_ok, .m_message_type, .m_last_report, .m_reports_dropped,
        .fail_count, .reports_pending
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[rtcm3_frame_sync_crc24q_core] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [23:0] crc24q_ref(input logic [7:0] q [$]);
        logic [24:0] c;
        c = '0;
        foreach (q[i]) begin
            c[23:16] = c[23:16] ^ q[i];
            for (int k = 0; k < 8; k++) begin
                c = {c[23:0], 1'b0};
                if (c[24]) begin
                    c = c ^ CRC_POLY;
                end
            end
        end
        return c[23:0];
    endfunction

    task automatic set_phase();
        case ((bytes_sent / 120) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        set_phase();
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_queue(input logic [7:0] q [$]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic build_frame(input int len, input bit good, output logic [7:0] q [$]);
        logic [23:0] crc;
        q = {SYNC_BYTE, 8'(len[9:8]), len[7:0]};
        for (int i = 0; i < len; i++) q = {q, 8'($urandom_range(255))};
        crc = crc24q_ref(q);
        if (!good) crc = crc ^ (24'h1 << $urandom_range(23));
        q = {q, crc[23:16], crc[15:8], crc[7:0]};
    endtask

    task automatic send_frame(input int len, input bit good);
        logic [7:0] q [$];
        build_frame(len, good, q);
        send_queue(q);
    endtask

    initial begin
        logic [7:0] q [$];
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = 8'h00;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 1);
        send_frame(1, 1);
        send_frame(2, 1);
        send_frame(3, 0);
        send_queue({SYNC_BYTE, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00});
        send_queue({SYNC_BYTE, 8'hFC, 8'h01, 8'h55});

        // long header holds scanning until a burst of short candidates completes
        q = {SYNC_BYTE, 8'h01, 8'h00};
        while (q.size() < 262) begin
            q = {q, SYNC_BYTE, 8'h00, 8'h00};
        end
        send_queue(q);

        // random
        while (bytes_sent < 470) begin
            if ($urandom_range(99) < 70) begin
                send_frame($urandom_range(20), $urandom_range(99) < 80);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end
        end
        s_valid <= 1'b0;

        while (reports_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[rtcm3_frame_sync_crc24q_core] OK");
        end else begin
            $display("[rtcm3_frame_sync_crc24q_core] ERROR");
        end
        $finish;
    end

endmodule
